// ----- src/stream_find_replace_assert.svh -----
// Assertion macros shared by the stream find-and-replace RTL.
`ifndef STREAM_FIND_REPLACE_ASSERT_SVH
`define STREAM_FIND_REPLACE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SFR_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define SFR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ----- src/sfr_pkg.sv -----
// Shared constants, types and register codes for the stream find-and-replace block.
package sfr_pkg;

    localparam int PATTERN_MAX = 8;
    localparam int REPLACE_MAX = 8;
    localparam int COUNT_WIDTH = 16;
    localparam int BYTE_W      = 8;
    localparam int DATA_W      = 64;
    localparam int LEN_W       = 4;
    localparam int FILL_W      = $clog2(PATTERN_MAX);
    localparam int SRC_MAX     = (PATTERN_MAX > REPLACE_MAX) ? PATTERN_MAX : REPLACE_MAX;
    // Worst case per input: a full set of bytes followed by the end marker.
    localparam int OQ_DEPTH    = SRC_MAX + 1;
    localparam int NUM_W       = $clog2(OQ_DEPTH + 1);
    localparam int IDX_W       = 2;

    // Configuration register indexes.
    typedef enum logic [IDX_W-1:0] {
        CFG_PAT_BYTES = 2'd0,
        CFG_PAT_LEN   = 2'd1,
        CFG_REP_BYTES = 2'd2,
        CFG_REP_LEN   = 2'd3
    } t_cfg_idx;

    // One result entry of the output queue.
    typedef struct packed {
        logic [BYTE_W-1:0]      data;
        logic                   marker;
        logic [COUNT_WIDTH-1:0] total;
        logic                   last;
    } t_result;

endpackage

// ----- src/sfr_win_cell.sv -----
// One byte cell of the matching window: holds a byte, compares it, shifts toward the head.
module sfr_win_cell (
    input  logic                       i_clk,
    input  logic                       i_en,
    input  logic                       i_load,
    input  logic                       i_shift,
    input  logic                       i_active,
    input  logic [sfr_pkg::BYTE_W-1:0] i_byte,
    input  logic [sfr_pkg::BYTE_W-1:0] i_next,
    input  logic [sfr_pkg::BYTE_W-1:0] i_pat,
    output logic [sfr_pkg::BYTE_W-1:0] o_byte,
    output logic                       o_match
);
    import sfr_pkg::*;

    logic [BYTE_W-1:0] r_byte;
    logic [BYTE_W-1:0] n_byte;

    // The cell's view after the incoming byte is written at the fill position.
    assign o_byte  = i_load ? i_byte : r_byte;
    assign o_match = !i_active || (o_byte == i_pat);

    // On a mismatch the window drops its oldest byte, so each cell takes its neighbor's byte.
    assign n_byte = i_shift ? i_next : o_byte;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_byte <= n_byte;
        end
    end

endmodule

// ----- src/sfr_out_cell.sv -----
// One entry of the output queue: loads a new result or takes its neighbor's entry on a transfer.
module sfr_out_cell (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  logic             i_load_vld,
    input  sfr_pkg::t_result i_load_res,
    input  logic             i_pop,
    input  logic             i_next_vld,
    input  sfr_pkg::t_result i_next_res,
    output logic             o_vld,
    output sfr_pkg::t_result o_res
);
    import sfr_pkg::*;

    logic    r_vld;
    logic    n_vld;
    t_result r_res;
    t_result n_res;

    // A load only happens when the queue is empty after this cycle's transfer.
    always_comb begin
        n_vld = r_vld;
        n_res = r_res;
        if (i_load) begin
            n_vld = i_load_vld;
            n_res = i_load_res;
        end else if (i_pop) begin
            n_vld = i_next_vld;
            n_res = i_next_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= n_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
    end

    assign o_vld = r_vld;
    assign o_res = r_res;

endmodule

// ----- src/stream_find_replace.sv -----
// Top level of the streaming find-and-replace block: config, window chain and output queue.
//
// Usage: text bytes enter on the input channel (i_in_valid / o_in_ready), one per transfer,
// with i_text_end set on the final byte of a text. Results leave on the output channel
// (o_out_valid / i_out_ready): text bytes, then an end marker carrying the number of
// replacements made in that text. o_run_last flags the last result caused by an input.
// Configuration is written through i_cfg_we / i_cfg_idx / i_cfg_wdata while the block is idle;
// writing the pattern length empties the window.
// Results of an input appear in the cycle after its transfer. Bytes that may still start
// a match are held in an eight-cell window, so plain bytes lag by fewer inputs than the
// pattern length. One input per cycle while each input yields at most one result and the
// receiver is ready. After an input with several results (a replacement burst or a flush
// with end marker, at most nine), the next input is taken as its last result transfers.
// A receiver stall holds the queue and therefore the input; nothing is dropped.
// Reset clears the configuration, the window fill, the match counter and the output queue.
`include "stream_find_replace_assert.svh"

module stream_find_replace (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [sfr_pkg::IDX_W-1:0]       i_cfg_idx,
    input  logic [sfr_pkg::DATA_W-1:0]      i_cfg_wdata,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [sfr_pkg::BYTE_W-1:0]      i_text_byte,
    input  logic                            i_text_end,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [sfr_pkg::BYTE_W-1:0]      o_out_byte,
    output logic                            o_is_marker,
    output logic [sfr_pkg::COUNT_WIDTH-1:0] o_match_total,
    output logic                            o_run_last
);
    import sfr_pkg::*;

    logic [DATA_W-1:0]      r_pat;
    logic [DATA_W-1:0]      r_rep;
    logic [LEN_W-1:0]       r_plen;
    logic [LEN_W-1:0]       r_rlen;
    logic [FILL_W-1:0]      r_fill;
    logic [FILL_W-1:0]      n_fill;
    logic [COUNT_WIDTH-1:0] r_cnt;
    logic [COUNT_WIDTH-1:0] n_cnt;

    logic [LEN_W-1:0]       eff_len;
    logic [LEN_W-1:0]       eff_rlen;
    logic                   acc;
    logic                   pop;
    logic                   full;
    logic                   hit;
    logic                   shift;
    logic                   match_all;
    logic [NUM_W-1:0]       nb;
    logic [NUM_W-1:0]       num;
    logic [COUNT_WIDTH-1:0] tot;

    logic [BYTE_W-1:0]      w_byte [PATTERN_MAX];
    logic [PATTERN_MAX-1:0] w_match;
    logic [BYTE_W-1:0]      src    [SRC_MAX];

    logic                   q_vld  [OQ_DEPTH];
    t_result                q_res  [OQ_DEPTH];
    logic                   ld_vld [OQ_DEPTH];
    t_result                ld_res [OQ_DEPTH];
    logic [OQ_DEPTH-1:0]    q_vld_vec;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat  <= '0;
            r_plen <= '0;
            r_rep  <= '0;
            r_rlen <= '0;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_PAT_BYTES: r_pat  <= i_cfg_wdata;
                CFG_PAT_LEN:   r_plen <= i_cfg_wdata[LEN_W-1:0];
                CFG_REP_BYTES: r_rep  <= i_cfg_wdata;
                CFG_REP_LEN:   r_rlen <= i_cfg_wdata[LEN_W-1:0];
                default: ;
            endcase
        end
    end

    // Oversized lengths are clamped to the window and replacement sizes.
    assign eff_len  = (r_plen > LEN_W'(PATTERN_MAX)) ? LEN_W'(PATTERN_MAX) : r_plen;
    assign eff_rlen = (r_rlen > LEN_W'(REPLACE_MAX)) ? LEN_W'(REPLACE_MAX) : r_rlen;

    // Handshakes: a new input is taken only when the queue is empty after this cycle.
    assign pop        = q_vld[0] && i_out_ready;
    assign o_in_ready = !q_vld[0] || (i_out_ready && !q_vld[1]);
    assign acc        = i_in_valid && o_in_ready;

    // Window chain. With an empty pattern the fill stays at zero, so cell zero shows the
    // incoming byte and the pass-through case reads it from there.
    for (genvar i = 0; i < PATTERN_MAX; i++) begin : g_win
        logic [BYTE_W-1:0] nxt;
        if (i == PATTERN_MAX - 1) begin : g_end
            assign nxt = '0;
        end else begin : g_mid
            assign nxt = w_byte[i+1];
        end
        sfr_win_cell u_cell (
            .i_clk    (i_clk),
            .i_en     (acc),
            .i_load   (r_fill == FILL_W'(i)),
            .i_shift  (shift),
            .i_active (LEN_W'(i) < eff_len),
            .i_byte   (i_text_byte),
            .i_next   (nxt),
            .i_pat    (r_pat[BYTE_W*i +: BYTE_W]),
            .o_byte   (w_byte[i]),
            .o_match  (w_match[i])
        );
    end

    assign match_all = &w_match;
    assign full      = (eff_len != '0) && ((LEN_W'(r_fill) + LEN_W'(1)) == eff_len);
    assign hit       = full && match_all;
    assign shift     = full && !match_all;

    // Byte source for the results of this input: replacement on a match, else the window.
    for (genvar k = 0; k < SRC_MAX; k++) begin : g_src
        logic [BYTE_W-1:0] rep_b;
        logic [BYTE_W-1:0] win_b;
        if (k < REPLACE_MAX) begin : g_rep
            assign rep_b = r_rep[BYTE_W*k +: BYTE_W];
        end else begin : g_norep
            assign rep_b = '0;
        end
        if (k < PATTERN_MAX) begin : g_w
            assign win_b = w_byte[k];
        end else begin : g_now
            assign win_b = '0;
        end
        assign src[k] = hit ? rep_b : win_b;
    end

    // Number of text bytes this input releases.
    always_comb begin
        if (eff_len == '0) begin
            nb = NUM_W'(1);
        end else if (hit) begin
            nb = NUM_W'(eff_rlen);
        end else if (i_text_end) begin
            nb = NUM_W'(r_fill) + NUM_W'(1);
        end else if (full) begin
            nb = NUM_W'(1);
        end else begin
            nb = '0;
        end
    end

    assign num = nb + NUM_W'(i_text_end);
    assign tot = (hit && (r_cnt != '1)) ? r_cnt + COUNT_WIDTH'(1) : r_cnt;

    // Next window fill and match counter.
    always_comb begin
        n_fill = r_fill;
        if (acc && (eff_len != '0)) begin
            if (i_text_end || hit) begin
                n_fill = '0;
            end else if (full) begin
                n_fill = FILL_W'(eff_len - LEN_W'(1));
            end else begin
                n_fill = r_fill + FILL_W'(1);
            end
        end else if (acc) begin
            n_fill = '0;
        end
        n_cnt = r_cnt;
        if (acc) begin
            n_cnt = i_text_end ? '0 : tot;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
            r_cnt  <= '0;
        end else begin
            r_cnt  <= n_cnt;
            if (i_cfg_we && (t_cfg_idx'(i_cfg_idx) == CFG_PAT_LEN)) begin
                r_fill <= '0;
            end else begin
                r_fill <= n_fill;
            end
        end
    end

    // Output queue: entry k of this input's results, then the cell row that holds them.
    for (genvar k = 0; k < OQ_DEPTH; k++) begin : g_oq
        logic    nxt_vld;
        t_result nxt_res;
        if (k < SRC_MAX) begin : g_b
            assign ld_res[k].data = (NUM_W'(k) < nb) ? src[k] : '0;
        end else begin : g_nb
            assign ld_res[k].data = '0;
        end
        assign ld_res[k].marker = i_text_end && (NUM_W'(k) == nb);
        assign ld_res[k].total  = tot;
        assign ld_res[k].last   = (NUM_W'(k) + NUM_W'(1)) == num;
        assign ld_vld[k]        = NUM_W'(k) < num;

        if (k == OQ_DEPTH - 1) begin : g_end
            assign nxt_vld = 1'b0;
            assign nxt_res = '0;
        end else begin : g_mid
            assign nxt_vld = q_vld[k+1];
            assign nxt_res = q_res[k+1];
        end

        sfr_out_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_load     (acc),
            .i_load_vld (ld_vld[k]),
            .i_load_res (ld_res[k]),
            .i_pop      (pop),
            .i_next_vld (nxt_vld),
            .i_next_res (nxt_res),
            .o_vld      (q_vld[k]),
            .o_res      (q_res[k])
        );
        assign q_vld_vec[k] = q_vld[k];
    end

    // Output ports come straight from the head entry's registers.
    assign o_out_valid   = q_vld[0];
    assign o_out_byte    = q_res[0].data;
    assign o_is_marker   = q_res[0].marker;
    assign o_match_total = q_res[0].total;
    assign o_run_last    = q_res[0].last;

    // The queue stays packed toward its head.
    `SFR_ASSERT_NOW(a_queue_packed, i_clk, i_rst_n, !q_vld[0], q_vld_vec == '0)
    // An input is taken only when at most the head entry remains.
    `SFR_ASSERT_NOW(a_ready_room, i_clk, i_rst_n, o_in_ready, $countones(q_vld_vec) <= 1)
    // The window never holds a full pattern between inputs.
    `SFR_ASSERT_NOW(a_fill_bound, i_clk, i_rst_n, eff_len != '0, LEN_W'(r_fill) < eff_len)
    // The end marker closes the results of its input.
    `SFR_ASSERT_NOW(a_marker_last, i_clk, i_rst_n, o_out_valid && o_is_marker, o_run_last)
    // The final byte of a text empties the window and clears the counter.
    `SFR_ASSERT_NEXT(a_end_flush, i_clk, i_rst_n, acc && i_text_end, (r_fill == '0) && (r_cnt == '0))

endmodule
